// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the angle pipeline modules
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define XYA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define XYA_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/xya_pkg.sv -----
// shared types and constants of the xy to angle pipeline
// no dependencies
package xya_pkg;

	localparam int REG_W           = 12;
	localparam int CFG_IDX_W       = 2;
	localparam int NORM_W          = 41;
	localparam int NORM_STEPS      = 6;
	localparam int ACC_FRAC        = 20;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int CW              = 44;
	localparam int ZW              = 29;
	localparam int FIXED_W         = 9 + ANGLE_FRAC_BITS;
	localparam int WHOLE_W         = 9;
	localparam int ATAN_LEN        = 24;

	localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 2'd3;

	localparam logic [ZW-1:0] DEG90  = ZW'(90) << ACC_FRAC;
	localparam logic [ZW-1:0] DEG180 = ZW'(180) << ACC_FRAC;
	localparam logic [ZW-1:0] DEG360 = ZW'(360) << ACC_FRAC;
	localparam logic [WHOLE_W-1:0] WHOLE_MAX = WHOLE_W'(360);

	typedef struct packed {
		logic fault;
		logic zero;
		logic negx;
		logic negy;
	} flags_t;

	// atan(2^-i) in degrees with ACC_FRAC fraction bits
	function automatic logic [ZW-1:0] atan_step(input int idx);
		logic [ZW-1:0] v;
		unique case (idx)
			0: v = ZW'(47185920);
			1: v = ZW'(27855475);
			2: v = ZW'(14718068);
			3: v = ZW'(7471121);
			4: v = ZW'(3750058);
			5: v = ZW'(1876857);
			6: v = ZW'(938658);
			7: v = ZW'(469357);
			8: v = ZW'(234682);
			9: v = ZW'(117342);
			10: v = ZW'(58671);
			11: v = ZW'(29335);
			12: v = ZW'(14668);
			13: v = ZW'(7334);
			14: v = ZW'(3667);
			15: v = ZW'(1833);
			16: v = ZW'(917);
			17: v = ZW'(458);
			18: v = ZW'(229);
			19: v = ZW'(115);
			20: v = ZW'(57);
			21: v = ZW'(29);
			22: v = ZW'(14);
			23: v = ZW'(7);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/core/xya_front.sv -----
// range registers, axis centring and span cross-multiply (two stages)
// depends on xya_pkg
module xya_front import xya_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [REG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample_x,
	input  logic [SAMPLE_BITS-1:0] sample_y,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [NORM_W-1:0]      out_ax,
	output logic [NORM_W-1:0]      out_ay,
	output flags_t                 out_flags
);

	localparam int MAG_W  = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
	localparam int DIFF_W = MAG_W + 1;
	localparam int PROD_W = MAG_W + REG_W;

	logic [REG_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;

	logic [REG_W:0]              sum_x, sum_y;
	logic signed [DIFF_W-1:0]    dx, dy, abs_dx, abs_dy;
	logic signed [REG_W:0]       spx, spy, abs_spx, abs_spy;
	flags_t                      flags_c;

	logic                v1_q, v2_q;
	logic                s1_ready, s2_ready;
	logic [MAG_W-1:0]    mag_dx_s1, mag_dy_s1;
	logic [REG_W-1:0]    mag_spx_s1, mag_spy_s1;
	flags_t              flags_s1, flags_s2;
	logic [PROD_W-1:0]   prod_x, prod_y;
	logic [NORM_W-1:0]   ax_s2, ay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= '0;
			x_high_q <= '1;
			y_low_q  <= '0;
			y_high_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_LOW:  x_low_q  <= cfg_data;
				REG_X_HIGH: x_high_q <= cfg_data;
				REG_Y_LOW:  y_low_q  <= cfg_data;
				REG_Y_HIGH: y_high_q <= cfg_data;
			endcase
		end
	end

	// truncated midpoint of each range
	assign sum_x = {1'b0, x_low_q} + {1'b0, x_high_q};
	assign sum_y = {1'b0, y_low_q} + {1'b0, y_high_q};

	always_comb begin
		dx = $signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, sample_x})
			- $signed({{(DIFF_W-REG_W){1'b0}}, sum_x[REG_W:1]});
		dy = $signed({{(DIFF_W-SAMPLE_BITS){1'b0}}, sample_y})
			- $signed({{(DIFF_W-REG_W){1'b0}}, sum_y[REG_W:1]});
		spx = $signed({1'b0, x_high_q}) - $signed({1'b0, x_low_q});
		spy = $signed({1'b0, y_high_q}) - $signed({1'b0, y_low_q});
		abs_dx  = dx[DIFF_W-1] ? -dx : dx;
		abs_dy  = dy[DIFF_W-1] ? -dy : dy;
		abs_spx = spx[REG_W] ? -spx : spx;
		abs_spy = spy[REG_W] ? -spy : spy;
		flags_c.fault = (spx == '0) || (spy == '0);
		flags_c.zero  = (dx == '0) && (dy == '0);
		// a centred value of zero never flips the quadrant
		flags_c.negx  = (dx != '0) && (dx[DIFF_W-1] ^ spx[REG_W]);
		flags_c.negy  = (dy != '0) && (dy[DIFF_W-1] ^ spy[REG_W]);
	end

	assign s2_ready = !v2_q || out_ready;
	assign s1_ready = !v1_q || s2_ready;
	assign in_ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (s1_ready) v1_q <= in_valid;
			if (s2_ready) v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			mag_dx_s1  <= abs_dx[MAG_W-1:0];
			mag_dy_s1  <= abs_dy[MAG_W-1:0];
			mag_spx_s1 <= abs_spx[REG_W-1:0];
			mag_spy_s1 <= abs_spy[REG_W-1:0];
			flags_s1   <= flags_c;
		end
	end

	// x is scaled by the y span and y by the x span
	assign prod_x = mag_dx_s1 * mag_spy_s1;
	assign prod_y = mag_dy_s1 * mag_spx_s1;

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			ax_s2    <= NORM_W'(prod_x);
			ay_s2    <= NORM_W'(prod_y);
			flags_s2 <= flags_s1;
		end
	end

	assign out_valid = v2_q;
	assign out_ax    = ax_s2;
	assign out_ay    = ay_s2;
	assign out_flags = flags_s2;

endmodule

// ----- rtl/core/xya_norm_cell.sv -----
// one step of the left-justify chain: shifts both axes when the top bits are clear
// depends on xya_pkg
module xya_norm_cell import xya_pkg::*; #(
	parameter int SHIFT = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NORM_W-1:0] in_ax,
	input  logic [NORM_W-1:0] in_ay,
	input  flags_t            in_flags,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NORM_W-1:0] out_ax,
	output logic [NORM_W-1:0] out_ay,
	output flags_t            out_flags
);

	logic [NORM_W-1:0] both, ax_n, ay_n, ax_q, ay_q;
	logic              top_clear, valid_q;
	flags_t            flags_q;

	// the larger axis has clear top bits exactly when their or does
	assign both      = in_ax | in_ay;
	assign top_clear = (both[NORM_W-1 -: SHIFT] == '0);
	assign ax_n      = top_clear ? (in_ax << SHIFT) : in_ax;
	assign ay_n      = top_clear ? (in_ay << SHIFT) : in_ay;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			ax_q    <= ax_n;
			ay_q    <= ay_n;
			flags_q <= in_flags;
		end
	end

	assign out_valid = valid_q;
	assign out_ax    = ax_q;
	assign out_ay    = ay_q;
	assign out_flags = flags_q;

endmodule

// ----- rtl/core/xya_cordic_cell.sv -----
// one vectoring micro-rotation of the cordic chain
// depends on xya_pkg
module xya_cordic_cell import xya_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] in_x,
	input  logic signed [CW-1:0] in_y,
	input  logic signed [ZW-1:0] in_z,
	input  flags_t               in_flags,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [CW-1:0] out_x,
	output logic signed [CW-1:0] out_y,
	output logic signed [ZW-1:0] out_z,
	output flags_t               out_flags
);

	localparam logic signed [ZW-1:0] ATAN = signed'(atan_step(IDX));

	logic signed [CW-1:0] xs, ys, x_n, y_n, x_q, y_q;
	logic signed [ZW-1:0] z_n, z_q;
	logic                 valid_q;
	flags_t               flags_q;

	assign xs = in_x >>> IDX;
	assign ys = in_y >>> IDX;

	// rotate towards the x axis; y of zero counts as above it
	always_comb begin
		if (!in_y[CW-1]) begin
			x_n = in_x + ys;
			y_n = in_y - xs;
			z_n = in_z + ATAN;
		end else begin
			x_n = in_x - ys;
			y_n = in_y + xs;
			z_n = in_z - ATAN;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			x_q     <= x_n;
			y_q     <= y_n;
			z_q     <= z_n;
			flags_q <= in_flags;
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_flags = flags_q;

endmodule

// ----- rtl/core/xya_back.sv -----
// quadrant mapping, rounding to fixed and whole degrees, output register
// depends on xya_pkg and assert_macros.svh
`include "assert_macros.svh"
module xya_back import xya_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [ZW-1:0] in_z,
	input  flags_t               in_flags,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [FIXED_W-1:0]   angle_fixed,
	output logic [WHOLE_W-1:0]   angle_whole,
	output logic                 span_fault
);

	localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam logic [ZW:0] RND_FIXED = (ZW+1)'(1) << (SH - 1);
	localparam logic [ZW:0] RND_WHOLE = (ZW+1)'(1) << (ACC_FRAC - 1);
	localparam logic [ZW:0] FIXED_LIM = (ZW+1)'(360) << ANGLE_FRAC_BITS;

	logic [ZW-1:0]      z_raw, t, acc;
	logic               v1_q, v2_q, s1_ready, s2_ready;
	logic [ZW-1:0]      acc_s1;
	flags_t             flags_s1;
	logic [ZW:0]        sum_fixed, sum_whole, fixed_full;
	logic [FIXED_W-1:0] fixed_c, fixed_s2;
	logic [WHOLE_W-1:0] whole_c, whole_s2;
	logic               fault_s2;

	assign z_raw = in_z;

	always_comb begin
		if (in_z[ZW-1]) begin
			t = '0;
		end else if (z_raw > DEG90) begin
			t = DEG90;
		end else begin
			t = z_raw;
		end
		unique case ({in_flags.negx, in_flags.negy})
			2'b00:   acc = t;
			2'b10:   acc = DEG180 - t;
			2'b11:   acc = DEG180 + t;
			default: acc = DEG360 - t;
		endcase
	end

	assign s2_ready = !v2_q || out_ready;
	assign s1_ready = !v1_q || s2_ready;
	assign in_ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (s1_ready) v1_q <= in_valid;
			if (s2_ready) v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			acc_s1   <= acc;
			flags_s1 <= in_flags;
		end
	end

	// round half up; a fixed angle that reaches 360 wraps to 0
	assign sum_fixed  = {1'b0, acc_s1} + RND_FIXED;
	assign sum_whole  = {1'b0, acc_s1} + RND_WHOLE;
	assign fixed_full = sum_fixed >> SH;

	always_comb begin
		if (flags_s1.fault || flags_s1.zero) begin
			fixed_c = '0;
			whole_c = '0;
		end else begin
			fixed_c = (fixed_full < FIXED_LIM) ? fixed_full[FIXED_W-1:0] : '0;
			whole_c = sum_whole[ACC_FRAC +: WHOLE_W];
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			fixed_s2 <= fixed_c;
			whole_s2 <= whole_c;
			fault_s2 <= flags_s1.fault;
		end
	end

	assign out_valid   = v2_q;
	assign angle_fixed = fixed_s2;
	assign angle_whole = whole_s2;
	assign span_fault  = fault_s2;

	`XYA_IMPLY(a_fault_zero, v2_q && fault_s2, fixed_s2 == '0 && whole_s2 == '0, "fault result not zero")
	`XYA_IMPLY(a_whole_range, v2_q, whole_s2 <= WHOLE_MAX, "whole angle above 360")
	`XYA_IMPLY(a_acc_range, v1_q, acc_s1 <= DEG360, "mapped angle above 360")

endmodule

// ----- rtl/core/xy_to_angle_degrees.sv -----
// stages: 2 centring/multiply, 6 left-justify cells, one cell per cordic rotation,
// 2 output; throughput: one request per clock unless m_tready stalls; each cell holds
// its own valid bit, so gaps close up and input is taken while a finished result
// waits in the output register
// reset: arst_n clears every valid bit and sets the ranges to 0..4095 on both axes
// depends on xya_pkg, xya_front, xya_norm_cell, xya_cordic_cell, xya_back
module xy_to_angle_degrees import xya_pkg::*; #(
	parameter int SAMPLE_BITS     = 12,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// sample_x, sample_y, zero pad
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// angle_fixed, angle_whole, zero pad
	output logic [31:0]          m_tdata,
	// span_fault
	output logic                 m_tuser
);

	localparam int NCELLS = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	logic              n_valid [0:NORM_STEPS];
	logic              n_ready [0:NORM_STEPS];
	logic [NORM_W-1:0] n_ax    [0:NORM_STEPS];
	logic [NORM_W-1:0] n_ay    [0:NORM_STEPS];
	flags_t            n_flags [0:NORM_STEPS];

	logic                 c_valid [0:NCELLS];
	logic                 c_ready [0:NCELLS];
	logic signed [CW-1:0] c_x     [0:NCELLS];
	logic signed [CW-1:0] c_y     [0:NCELLS];
	logic signed [ZW-1:0] c_z     [0:NCELLS];
	flags_t               c_flags [0:NCELLS];

	logic [FIXED_W-1:0] angle_fixed;
	logic [WHOLE_W-1:0] angle_whole;

	xya_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sample_x  (s_tdata[SAMPLE_BITS-1:0]),
		.sample_y  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.out_valid (n_valid[0]),
		.out_ready (n_ready[0]),
		.out_ax    (n_ax[0]),
		.out_ay    (n_ay[0]),
		.out_flags (n_flags[0])
	);

	// shifts of 32, 16, 8, 4, 2, 1 bring the larger axis to the top bit
	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
		xya_norm_cell #(
			.SHIFT(1 << (NORM_STEPS - 1 - k))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (n_valid[k]),
			.in_ready  (n_ready[k]),
			.in_ax     (n_ax[k]),
			.in_ay     (n_ay[k]),
			.in_flags  (n_flags[k]),
			.out_valid (n_valid[k+1]),
			.out_ready (n_ready[k+1]),
			.out_ax    (n_ax[k+1]),
			.out_ay    (n_ay[k+1]),
			.out_flags (n_flags[k+1])
		);
	end

	assign c_valid[0]          = n_valid[NORM_STEPS];
	assign n_ready[NORM_STEPS] = c_ready[0];
	assign c_x[0]              = CW'(n_ax[NORM_STEPS]);
	assign c_y[0]              = CW'(n_ay[NORM_STEPS]);
	assign c_z[0]              = '0;
	assign c_flags[0]          = n_flags[NORM_STEPS];

	for (genvar i = 0; i < NCELLS; i++) begin : g_cordic
		xya_cordic_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.in_x      (c_x[i]),
			.in_y      (c_y[i]),
			.in_z      (c_z[i]),
			.in_flags  (c_flags[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.out_x     (c_x[i+1]),
			.out_y     (c_y[i+1]),
			.out_z     (c_z[i+1]),
			.out_flags (c_flags[i+1])
		);
	end

	xya_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (c_valid[NCELLS]),
		.in_ready    (c_ready[NCELLS]),
		.in_z        (c_z[NCELLS]),
		.in_flags    (c_flags[NCELLS]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.angle_fixed (angle_fixed),
		.angle_whole (angle_whole),
		.span_fault  (m_tuser)
	);

	assign m_tdata = {{(32-FIXED_W-WHOLE_W){1'b0}}, angle_whole, angle_fixed};

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for xy_to_angle_degrees: a directed table, then randomised phases
// with new axis ranges, checked against a bit-accurate cordic angle predictor
// depends on xya_pkg and the xy_to_angle_degrees rtl
module tb_top;
	import xya_pkg::*;

	localparam int SB         = 12;
	localparam int SDW        = ((2*SB+7)/8)*8;
	localparam int STAGES     = 16;
	localparam int ROT_STEPS  = (STAGES < 24) ? STAGES : 24;
	localparam int ANG_FRAC   = ANGLE_FRAC_BITS;
	localparam int SETTLE     = STAGES + 30;
	localparam int CYCLE_CAP  = 400000;
	localparam int PHASES     = 12;
	localparam int PHASE_ITEMS = 105;

	typedef struct packed {
		logic [FIXED_W-1:0] fixed;
		logic [WHOLE_W-1:0] whole;
		logic               fault;
	} angle_res_t;

	typedef struct {
		int xl, xh, yl, yh;
		int sx, sy;
		bit typed;
		angle_res_t want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [SDW-1:0]       s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;
	logic                 m_tuser;

	// atan(2^-i) in degrees, 20 fraction bits
	longint atan_deg [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
		469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	int rng_xl = 0, rng_xh = 4095, rng_yl = 0, rng_yh = 4095;
	angle_res_t angle_due [$];
	stim_row_t  dir_rows [$];
	int errors = 0;
	int cycles = 0;
	bit gaps_on = 1'b1;

	xy_to_angle_degrees #(
		.SAMPLE_BITS(SB),
		.CORDIC_STAGES(STAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// first-quadrant angle, left-justified then rotated towards the x axis
	function automatic longint quadrant_deg(input longint unsigned ax, input longint unsigned ay);
		longint unsigned m;
		longint x, y, z, xs, ys;
		m = (ax > ay) ? ax : ay;
		while (m < (64'd1 << 40)) begin
			m = m << 1;
			ax = ax << 1;
			ay = ay << 1;
		end
		x = longint'(ax);
		y = longint'(ay);
		z = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_deg[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_deg[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > (longint'(90) << 20))
			z = longint'(90) << 20;
		return z;
	endfunction

	function automatic angle_res_t direction_of(input int sx, input int sy);
		int dx, dy, spx, spy;
		longint unsigned ax, ay, fx, wh;
		bit nx, ny;
		longint t, acc;
		angle_res_t r;
		r = '0;
		dx = (sx & 12'hFFF) - ((rng_xl + rng_xh) >> 1);
		dy = (sy & 12'hFFF) - ((rng_yl + rng_yh) >> 1);
		spx = rng_xh - rng_xl;
		spy = rng_yh - rng_yl;
		if (spx == 0 || spy == 0) begin
			r.fault = 1'b1;
			return r;
		end
		ax = longint'(dx < 0 ? -dx : dx) * longint'(spy < 0 ? -spy : spy);
		ay = longint'(dy < 0 ? -dy : dy) * longint'(spx < 0 ? -spx : spx);
		if (ax == 0 && ay == 0)
			return r;
		// a centred value of zero counts as positive
		nx = (ax != 0) && ((dx < 0) != (spx < 0));
		ny = (ay != 0) && ((dy < 0) != (spy < 0));
		t = quadrant_deg(ax, ay);
		if (!nx && !ny)
			acc = t;
		else if (nx && !ny)
			acc = (longint'(180) << 20) - t;
		else if (nx && ny)
			acc = (longint'(180) << 20) + t;
		else
			acc = (longint'(360) << 20) - t;
		fx = (longint'(acc) + (64'd1 << (20 - ANG_FRAC - 1))) >> (20 - ANG_FRAC);
		if (fx >= (64'd360 << ANG_FRAC))
			fx = 0;
		wh = (longint'(acc) + (64'd1 << 19)) >> 20;
		r.fixed = fx[FIXED_W-1:0];
		r.whole = wh[WHOLE_W-1:0];
		return r;
	endfunction

	task automatic flag_error(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	task automatic row(input int xl, input int xh, input int yl, input int yh,
			input int sx, input int sy, input bit typed = 1'b0,
			input int ef = 0, input int ew = 0, input int eflt = 0);
		stim_row_t r;
		r.xl = xl; r.xh = xh; r.yl = yl; r.yh = yh;
		r.sx = sx; r.sy = sy;
		r.typed = typed;
		r.want.fixed = FIXED_W'(ef);
		r.want.whole = WHOLE_W'(ew);
		r.want.fault = eflt[0];
		dir_rows.push_back(r);
	endtask

	// hold the sender off until every pending angle is back, plus pipeline slack
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		while (angle_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_ranges(input int xl, input int xh, input int yl, input int yh);
		int vals [4];
		logic [CFG_IDX_W-1:0] idx [4];
		vals = '{xl, xh, yl, yh};
		idx = '{REG_X_LOW, REG_X_HIGH, REG_Y_LOW, REG_Y_HIGH};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= REG_W'(vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		rng_xl = xl; rng_xh = xh; rng_yl = yl; rng_yh = yh;
	endtask

	task automatic send_sample(input int sx, input int sy, input bit typed, input angle_res_t want);
		while (gaps_on && $urandom_range(99) < 22) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= SDW'({SB'(sy), SB'(sx)});
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		angle_due.push_back(typed ? want : direction_of(sx, sy));
	endtask

	// one axis range: ordinary half the time, with reversed, zero-span and extreme cases mixed in
	task automatic pick_range(output int lo, output int hi);
		int kind, a, b;
		kind = $urandom_range(9);
		a = $urandom_range(4095);
		b = $urandom_range(4095);
		unique case (kind)
			0: begin lo = 0; hi = 4095; end
			1: begin lo = a; hi = a; end
			2: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
			3: begin lo = 0; hi = 1; end
			4: begin lo = 4094; hi = 4095; end
			5: begin lo = 4095; hi = 0; end
			default: begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
				if (lo == hi)
					hi = (lo == 4095) ? 0 : lo + 1;
			end
		endcase
	endtask

	function automatic int pick_sample(input int lo, input int hi);
		int kind, mn, mx;
		kind = $urandom_range(99);
		mn = (lo < hi) ? lo : hi;
		mx = (lo < hi) ? hi : lo;
		if (kind < 70)
			return $urandom_range(mx, mn);
		else if (kind < 80)
			return (lo + hi) >> 1;
		return $urandom_range(4095);
	endfunction

	// result side: compare at the edge, then choose the next stall
	always @(posedge clk) begin
		angle_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (angle_due.size() == 0) begin
				flag_error($sformatf("result with nothing pending, data %h user %b",
					m_tdata, m_tuser));
			end else begin
				exp_r = angle_due.pop_front();
				if (m_tdata[FIXED_W-1:0] !== exp_r.fixed)
					flag_error($sformatf("angle_fixed got %0d want %0d",
						m_tdata[FIXED_W-1:0], exp_r.fixed));
				if (m_tdata[FIXED_W+WHOLE_W-1:FIXED_W] !== exp_r.whole)
					flag_error($sformatf("angle_whole got %0d want %0d",
						m_tdata[FIXED_W+WHOLE_W-1:FIXED_W], exp_r.whole));
				if (m_tuser !== exp_r.fault)
					flag_error($sformatf("span_fault got %b want %b", m_tuser, exp_r.fault));
			end
		end
		m_tready <= !gaps_on || ($urandom_range(99) >= 22);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("FAIL xy_to_angle_degrees");
			$finish;
		end
	end

	initial begin
		int xl, xh, yl, yh;
		stim_row_t r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ranges: centre 2047 on both axes
		row(0, 4095, 0, 4095, 2047, 2047, 1'b1, 0, 0, 0);
		row(0, 4095, 0, 4095, 4095, 2047);
		row(0, 4095, 0, 4095, 0, 2047);
		row(0, 4095, 0, 4095, 2047, 4095);
		row(0, 4095, 0, 4095, 2047, 0);
		row(0, 4095, 0, 4095, 0, 0);
		row(0, 4095, 0, 4095, 4095, 4095);
		row(0, 4095, 0, 4095, 4095, 0);
		row(0, 4095, 0, 4095, 0, 4095);
		row(0, 4095, 0, 4095, 2048, 2047);
		row(0, 4095, 0, 4095, 2047, 2048);
		// tiny x span: an angle just under 360 rounds up and wraps
		row(0, 1, 0, 4095, 4095, 2046);
		row(0, 1, 0, 4095, 0, 2047, 1'b1, 0, 0, 0);
		// zero span on one or both axes
		row(100, 100, 0, 4095, 500, 600, 1'b1, 0, 0, 1);
		row(100, 100, 0, 4095, 100, 2047, 1'b1, 0, 0, 1);
		row(0, 4095, 4095, 4095, 0, 0, 1'b1, 0, 0, 1);
		row(0, 0, 0, 0, 4095, 4095, 1'b1, 0, 0, 1);
		// reversed ranges mirror both axes, then narrow two-code ranges
		row(4095, 0, 4095, 0, 4095, 2047);
		row(4095, 0, 4095, 0, 0, 0);
		row(4095, 0, 4095, 0, 4095, 4095);
		row(4095, 0, 4095, 0, 2047, 2047, 1'b1, 0, 0, 0);
		row(4094, 4095, 0, 1, 4095, 1);
		row(4094, 4095, 0, 1, 0, 0);

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.xl != rng_xl || r.xh != rng_xh || r.yl != rng_yl || r.yh != rng_yh) begin
				drain_pipe();
				write_ranges(r.xl, r.xh, r.yl, r.yh);
			end
			send_sample(r.sx, r.sy, r.typed, r.want);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_pipe();
			pick_range(xl, xh);
			pick_range(yl, yh);
			write_ranges(xl, xh, yl, yh);
			// one phase runs back to back on both sides
			gaps_on = (p != 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 6 && n == PHASE_ITEMS / 2)
					drain_pipe();
				send_sample(pick_sample(xl, xh), pick_sample(yl, yh), 1'b0, '0);
			end
		end
		gaps_on = 1'b1;

		drain_pipe();
		if (errors == 0) begin
			$display("PASS xy_to_angle_degrees");
		end else begin
			$display("FAIL xy_to_angle_degrees");
		end
		$finish;
	end

endmodule

// ----- xy_to_angle_degrees.f -----
+incdir+rtl/core
rtl/core/xya_pkg.sv
rtl/core/xya_front.sv
rtl/core/xya_norm_cell.sv
rtl/core/xya_cordic_cell.sv
rtl/core/xya_back.sv
rtl/core/xy_to_angle_degrees.sv
tb/tb_top.sv
